@@ src/imu_offset_calibrator_defines.svh @@
// Assertion macros for the offset calibrator modules.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef IMU_OFFSET_CALIBRATOR_DEFINES_SVH
`define IMU_OFFSET_CALIBRATOR_DEFINES_SVH

// Condition that must hold at every edge out of reset.
`define IMU_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define IMU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/imu_cal_pkg.sv @@
// Shared types, constants and tables for the IMU offset calibrator.
// No dependencies.
package imu_cal_pkg;

    localparam int SAMPLE_COUNT = 1000;

    typedef enum logic [1:0] {
        CMD_CORRECT = 2'd0,
        CMD_CAL     = 2'd1,
        CMD_LOAD    = 2'd2
    } t_cmd;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE  = 1'd1;

    // Calibration item counter, able to hold SAMPLE_COUNT itself.
    localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);

    // Running sum kept as quotient and remainder against SAMPLE_COUNT.
    localparam int REM_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int BIAS_Q = (32768 + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
    localparam int BIAS = BIAS_Q * SAMPLE_COUNT;
    localparam int T_MAX = SAMPLE_COUNT - 1 + 32767 + BIAS;
    localparam int T_W = $clog2(T_MAX + 1);
    localparam int ADD_W = T_W + 1;
    localparam int DIV_L = $clog2(SAMPLE_COUNT);
    localparam int RECIP_K = T_W + DIV_L;
    localparam longint RECIP_M =
        ((longint'(1) << RECIP_K) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
    localparam int M_W = $clog2(RECIP_M + 1);
    localparam int PROD_W = T_W + M_W;
    localparam int QT_MAX = T_MAX / SAMPLE_COUNT;
    localparam int QT_W = $clog2(QT_MAX + 1);
    localparam int QN_W = QT_W + CNT_W;
    localparam int Q_SUM_W = ((QT_W > 16) ? QT_W : 16) + 2;

    typedef logic [2:0][15:0] t_vec3;

    typedef struct packed {
        logic accum;
        logic finish;
        logic load;
    } t_lane_ctl;

    localparam logic [15:0] ONE_G [4] = '{16'd16384, 16'd8192, 16'd4096, 16'd2048};

    // Entries are {z, y, x}.
    localparam t_vec3 FACTORY_ACCEL [4] = '{
        {-16'sd1406, 16'sd226, -16'sd453},
        {-16'sd702, 16'sd111, -16'sd226},
        {16'sd49, -16'sd50, 16'sd111},
        {-16'sd167, -16'sd21, 16'sd54}
    };

    localparam t_vec3 FACTORY_GYRO [4] = '{
        {-16'sd198, 16'sd204, -16'sd443},
        {-16'sd99, 16'sd101, -16'sd221},
        {-16'sd25, 16'sd25, -16'sd55},
        {-16'sd26, 16'sd23, -16'sd56}
    };

endpackage

@@ src/imu_cal_axis.sv @@
// One axis: offset subtraction, running average and offset register.
// Depends on imu_cal_pkg.
module imu_cal_axis (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  imu_cal_pkg::t_lane_ctl  i_ctl,
    input  logic signed [15:0]      i_sample,
    input  logic [15:0]             i_factory,
    input  logic [15:0]             i_g_sub,
    output logic signed [15:0]      o_corrected
);

    logic signed [15:0]                r_offset;
    logic signed [15:0]                r_quot;
    logic [imu_cal_pkg::REM_W-1:0]     r_rem;

    logic [imu_cal_pkg::ADD_W-1:0]     add_t;
    logic [imu_cal_pkg::T_W-1:0]       t_val;
    logic [imu_cal_pkg::PROD_W-1:0]    prod;
    logic [imu_cal_pkg::QT_W-1:0]      qt;
    logic [imu_cal_pkg::QN_W-1:0]      qn;
    logic [imu_cal_pkg::Q_SUM_W-1:0]   q_sum;
    logic [imu_cal_pkg::REM_W-1:0]     n_rem;
    logic [15:0]                       n_quot;
    logic [15:0]                       avg;
    logic [15:0]                       n_avg_offset;

    assign o_corrected = i_sample - r_offset;

    // Remainder plus sample, lifted by a multiple of SAMPLE_COUNT to stay non-negative.
    always_comb begin
        add_t = {{(imu_cal_pkg::ADD_W-16){i_sample[15]}}, i_sample}
              + imu_cal_pkg::ADD_W'(r_rem)
              + imu_cal_pkg::ADD_W'(imu_cal_pkg::BIAS);
        t_val = add_t[imu_cal_pkg::T_W-1:0];
        prod  = imu_cal_pkg::PROD_W'(t_val) * imu_cal_pkg::PROD_W'(imu_cal_pkg::RECIP_M);
        qt    = imu_cal_pkg::QT_W'(prod >> imu_cal_pkg::RECIP_K);
        qn    = imu_cal_pkg::QN_W'(qt) * imu_cal_pkg::QN_W'(imu_cal_pkg::SAMPLE_COUNT);
        n_rem = imu_cal_pkg::REM_W'(t_val - imu_cal_pkg::T_W'(qn));
        q_sum = {{(imu_cal_pkg::Q_SUM_W-16){r_quot[15]}}, r_quot}
              + imu_cal_pkg::Q_SUM_W'(qt)
              - imu_cal_pkg::Q_SUM_W'(imu_cal_pkg::BIAS_Q);
        n_quot = q_sum[15:0];
        // Floor quotient to truncation toward zero.
        avg = n_quot + {15'd0, (n_quot[15] && (n_rem != '0))};
        n_avg_offset = avg - i_g_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_quot   <= '0;
            r_rem    <= '0;
        end else if (i_advance) begin
            if (i_ctl.finish) begin
                r_quot   <= '0;
                r_rem    <= '0;
                r_offset <= n_avg_offset;
            end else if (i_ctl.accum) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
            end
            if (i_ctl.load) begin
                r_offset <= i_factory;
            end
        end
    end

endmodule

@@ src/imu_cal_seq.sv @@
// Command decode and calibration item counter.
// Depends on imu_cal_pkg and imu_offset_calibrator_defines.svh.
`include "imu_offset_calibrator_defines.svh"

module imu_cal_seq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  logic [1:0]              i_cmd,
    output imu_cal_pkg::t_lane_ctl  o_ctl
);

    logic [imu_cal_pkg::CNT_W-1:0] r_count;
    logic [imu_cal_pkg::CNT_W-1:0] n_count;

    assign n_count = r_count + 1'b1;

    always_comb begin
        o_ctl = '0;
        case (i_cmd)
            imu_cal_pkg::CMD_CAL: begin
                o_ctl.accum  = 1'b1;
                o_ctl.finish = (n_count == imu_cal_pkg::CNT_W'(imu_cal_pkg::SAMPLE_COUNT));
            end
            imu_cal_pkg::CMD_LOAD: begin
                o_ctl.load = 1'b1;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_advance) begin
            if (o_ctl.finish) begin
                r_count <= '0;
            end else if (o_ctl.accum) begin
                r_count <= n_count;
            end
        end
    end

    `IMU_ASSERT_NOW(a_count_range, r_count < imu_cal_pkg::CNT_W'(imu_cal_pkg::SAMPLE_COUNT), "calibration count out of range")
    `IMU_ASSERT_NEXT(a_count_clear, i_advance && o_ctl.finish, r_count == '0, "count not cleared after averaging")
    `IMU_ASSERT_NEXT(a_count_step, i_advance && o_ctl.accum && !o_ctl.finish, r_count == $past(r_count) + 1'b1, "count did not advance on calibration item")
    `IMU_ASSERT_NEXT(a_count_hold, !i_advance, $stable(r_count), "count moved without an item")

endmodule

@@ src/imu_offset_calibrator.sv @@
// Top level of the six-axis IMU offset calibrator.
// Depends on imu_cal_pkg, imu_cal_seq and imu_cal_axis.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_command, i_raw_accel_*, i_raw_gyro_*
//   out      output     o_out_valid / i_out_ready o_corrected_*, o_calibration_finished
//   cfg      input      i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// One item per cycle sustained while results are taken; an accepted item is held
// in the input register, then moves into the result register on an advance.
// Offsets update on the edge an item moves into the result register, so the
// next item already sees them; each axis keeps its sum as quotient and
// remainder and folds one sample in through a narrow reciprocal multiply.
// Synchronous active-low reset clears handshake state, ranges, offsets and sums.
// A stalled result holds; the input register still refills when it drains.
module imu_offset_calibrator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [imu_cal_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [imu_cal_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_command,
    input  logic signed [15:0]                  i_raw_accel_x,
    input  logic signed [15:0]                  i_raw_accel_y,
    input  logic signed [15:0]                  i_raw_accel_z,
    input  logic signed [15:0]                  i_raw_gyro_x,
    input  logic signed [15:0]                  i_raw_gyro_y,
    input  logic signed [15:0]                  i_raw_gyro_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [15:0]                  o_corrected_accel_x,
    output logic signed [15:0]                  o_corrected_accel_y,
    output logic signed [15:0]                  o_corrected_accel_z,
    output logic signed [15:0]                  o_corrected_gyro_x,
    output logic signed [15:0]                  o_corrected_gyro_y,
    output logic signed [15:0]                  o_corrected_gyro_z,
    output logic                                o_calibration_finished
);

    logic [1:0]                 r_accel_range;
    logic [1:0]                 r_gyro_range;

    logic                       r_in_valid;
    logic [1:0]                 r_in_cmd;
    imu_cal_pkg::t_vec3         r_in_accel;
    imu_cal_pkg::t_vec3         r_in_gyro;

    logic                       r_out_valid;
    imu_cal_pkg::t_vec3         r_out_accel;
    imu_cal_pkg::t_vec3         r_out_gyro;
    logic                       r_out_finished;

    logic                       advance;
    logic                       in_fire;
    imu_cal_pkg::t_lane_ctl     ctl;
    imu_cal_pkg::t_vec3         corr_accel;
    imu_cal_pkg::t_vec3         corr_gyro;
    imu_cal_pkg::t_vec3         fac_accel;
    imu_cal_pkg::t_vec3         fac_gyro;
    logic [15:0]                one_g;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    assign fac_accel = imu_cal_pkg::FACTORY_ACCEL[r_accel_range];
    assign fac_gyro  = imu_cal_pkg::FACTORY_GYRO[r_gyro_range];
    assign one_g     = imu_cal_pkg::ONE_G[r_accel_range];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_range <= '0;
            r_gyro_range  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                imu_cal_pkg::CFG_ACCEL_RANGE: r_accel_range <= i_cfg_data;
                imu_cal_pkg::CFG_GYRO_RANGE:  r_gyro_range  <= i_cfg_data;
                default: begin
                    r_accel_range <= r_accel_range;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_cmd   <= i_command;
            r_in_accel <= {i_raw_accel_z, i_raw_accel_y, i_raw_accel_x};
            r_in_gyro  <= {i_raw_gyro_z, i_raw_gyro_y, i_raw_gyro_x};
        end
        if (advance) begin
            r_out_accel    <= corr_accel;
            r_out_gyro     <= corr_gyro;
            r_out_finished <= ctl.finish;
        end
    end

    imu_cal_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_cmd     (r_in_cmd),
        .o_ctl     (ctl)
    );

    for (genvar a = 0; a < 3; a++) begin : g_axis
        imu_cal_axis u_accel (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (advance),
            .i_ctl       (ctl),
            .i_sample    (r_in_accel[a]),
            .i_factory   (fac_accel[a]),
            .i_g_sub     ((a == 2) ? one_g : 16'd0),
            .o_corrected (corr_accel[a])
        );

        imu_cal_axis u_gyro (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (advance),
            .i_ctl       (ctl),
            .i_sample    (r_in_gyro[a]),
            .i_factory   (fac_gyro[a]),
            .i_g_sub     (16'd0),
            .o_corrected (corr_gyro[a])
        );
    end

    assign o_out_valid            = r_out_valid;
    assign o_corrected_accel_x    = r_out_accel[0];
    assign o_corrected_accel_y    = r_out_accel[1];
    assign o_corrected_accel_z    = r_out_accel[2];
    assign o_corrected_gyro_x     = r_out_gyro[0];
    assign o_corrected_gyro_y     = r_out_gyro[1];
    assign o_corrected_gyro_z     = r_out_gyro[2];
    assign o_calibration_finished = r_out_finished;

endmodule
